[src/aged_fifo_id_allocator_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the aged FIFO ID allocator
// Same-cycle and next-cycle implication checks on a clock with sync reset.
// ----------------------------------------------------------------------------
`ifndef AGED_FIFO_ID_ALLOCATOR_ASSERT_SVH
`define AGED_FIFO_ID_ALLOCATOR_ASSERT_SVH

// ante implies cons in the same cycle
`define AFID_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// ante implies cons in the next cycle
`define AFID_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/afid_pkg.sv]
// ----------------------------------------------------------------------------
// afid_pkg
// Widths, reset values, codes and controller/datapath structs of the allocator.
// ----------------------------------------------------------------------------
package afid_pkg;

   localparam int ID_W            = 8;
   localparam int TS_W            = 64;
   localparam int TIME_W          = 32;
   localparam int KIND_W          = 2;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = 32;
   localparam int NUM_IDS_DEFAULT = 256;

   localparam logic [ID_W-1:0]   MAX_ID_RESET   = 8'd255;
   localparam logic [TIME_W-1:0] MIN_FREE_RESET = 32'd2000000;

   localparam logic [CSR_IDX_W-1:0] REG_MAX_ID   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_FREE = 2'd1;

   typedef enum logic [KIND_W-1:0] {
      KIND_ALLOC = 2'd0,
      KIND_FREE  = 2'd1,
      KIND_QUERY = 2'd2
   } kind_type;

   typedef struct packed {
      logic sweep;
      logic load;
      logic rd_head;
      logic rd_stamp;
      logic rd_bit;
      logic alloc_commit;
      logic free_commit;
      logic query_commit;
      logic nop_commit;
   } cmd_type;

   typedef struct packed {
      logic reinit;
      logic sweep_last;
      logic out_free;
   } status_type;

endpackage

[src/afid_if.sv]
// ----------------------------------------------------------------------------
// afid channel interfaces
// Request, response and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface afid_req_if;
   logic                        valid;
   logic                        ready;
   logic [afid_pkg::KIND_W-1:0] kind;
   logic [afid_pkg::ID_W-1:0]   id_in;
   logic [afid_pkg::TS_W-1:0]   timestamp;
   modport source (output valid, kind, id_in, timestamp, input ready);
   modport sink   (input valid, kind, id_in, timestamp, output ready);
endinterface

interface afid_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [afid_pkg::ID_W-1:0] granted_id;
   logic                      flag;
   modport source (output valid, granted_id, flag, input ready);
   modport sink   (input valid, granted_id, flag, output ready);
endinterface

interface afid_csr_if;
   logic                            valid;
   logic                            ready;
   logic [afid_pkg::CSR_IDX_W-1:0]  index;
   logic [afid_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[src/afid_ctrl.sv]
// ----------------------------------------------------------------------------
// afid_ctrl
// Sequencer: clearing pass, request decode, memory read steps and commit.
// ----------------------------------------------------------------------------
module afid_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [afid_pkg::KIND_W-1:0] req_kind,
   output logic                        req_ready,
   input  afid_pkg::status_type        status,
   output afid_pkg::cmd_type           cmd
);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_RD_STAMP,
      ST_ALLOC,
      ST_FREE,
      ST_QUERY,
      ST_NOP
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            cmd.sweep = 1'b1;
            if (status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid && req_ready_ff) begin
               cmd.load = 1'b1;
               unique case (afid_pkg::kind_type'(req_kind))
                  afid_pkg::KIND_ALLOC: begin
                     cmd.rd_head = 1'b1;
                     state_in    = ST_RD_STAMP;
                  end
                  afid_pkg::KIND_FREE: begin
                     cmd.rd_bit = 1'b1;
                     state_in   = ST_FREE;
                  end
                  afid_pkg::KIND_QUERY: begin
                     cmd.rd_bit = 1'b1;
                     state_in   = ST_QUERY;
                  end
                  default: state_in = ST_NOP;
               endcase
            end
         end
         ST_RD_STAMP: begin
            cmd.rd_stamp = 1'b1;
            state_in     = ST_ALLOC;
         end
         ST_ALLOC: begin
            if (status.out_free) begin
               cmd.alloc_commit = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         ST_FREE: begin
            if (status.out_free) begin
               cmd.free_commit = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_QUERY: begin
            if (status.out_free) begin
               cmd.query_commit = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         ST_NOP: begin
            if (status.out_free) begin
               cmd.nop_commit = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
      if (status.reinit) state_in = ST_INIT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         req_ready_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == ST_IDLE);
      end
   end

   assign req_ready = req_ready_ff;

endmodule

[src/afid_datapath.sv]
// ----------------------------------------------------------------------------
// afid_datapath
// Registers, free queue, stamp and allocated-bit memories, age compare and
// the response register.
// ----------------------------------------------------------------------------
module afid_datapath #(
   parameter int NUM_IDS = afid_pkg::NUM_IDS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  afid_pkg::cmd_type               cmd,
   output afid_pkg::status_type            status,
   input  logic                            csr_valid,
   input  logic [afid_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [afid_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic [afid_pkg::ID_W-1:0]       req_id,
   input  logic [afid_pkg::TS_W-1:0]       req_timestamp,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [afid_pkg::ID_W-1:0]       rsp_granted_id,
   output logic                            rsp_flag
);

   localparam int IdW  = $clog2(NUM_IDS);
   localparam int CntW = IdW + 1;
   localparam int XW   = (IdW > afid_pkg::ID_W) ? IdW : afid_pkg::ID_W;
   localparam logic [IdW-1:0] LastIdx = IdW'(NUM_IDS - 1);

   logic [afid_pkg::ID_W-1:0]   max_id_ff;
   logic [afid_pkg::TIME_W-1:0] min_free_ff;
   logic [IdW-1:0]              sweep_ff;
   logic [IdW-1:0]              head_ff;
   logic [IdW-1:0]              tail_ff;
   logic [CntW-1:0]             count_ff;
   logic [afid_pkg::ID_W-1:0]   id_ff;
   logic [afid_pkg::TS_W-1:0]   ts_ff;
   logic [IdW-1:0]              cand_ff;
   logic [afid_pkg::TS_W-1:0]   stamp_rd_ff;
   logic                        bit_rd_ff;
   logic                        rsp_valid_ff;
   logic [afid_pkg::ID_W-1:0]   rsp_id_ff;
   logic                        rsp_flag_ff;

   logic [afid_pkg::ID_W-1:0]   rsp_id_in;
   logic                        rsp_flag_in;

   logic [IdW-1:0]              queue_mem [NUM_IDS];
   logic [afid_pkg::TS_W-1:0]   stamp_mem [NUM_IDS];
   logic                        alloc_mem [NUM_IDS];

   logic                        reinit;
   logic [XW-1:0]               max_x;
   logic [XW-1:0]               top_x;
   logic [IdW-1:0]              top_id;
   logic [XW-1:0]               id_x;
   logic [XW-1:0]               rid_x;
   logic [XW-1:0]               cand_x;
   logic                        id_ok;
   logic [afid_pkg::TS_W-1:0]   age;
   logic [afid_pkg::TS_W-1:0]   stamp_init;
   logic                        grant;
   logic                        free_ok;
   logic                        commit;

   function automatic logic [IdW-1:0] next_slot(input logic [IdW-1:0] ptr);
      return (ptr == LastIdx) ? '0 : IdW'(ptr + 1'b1);
   endfunction

   assign reinit = csr_valid &&
                   (csr_index == afid_pkg::REG_MAX_ID || csr_index == afid_pkg::REG_MIN_FREE);

   assign max_x      = XW'(max_id_ff);
   assign top_x      = (max_x > XW'(NUM_IDS - 1)) ? XW'(NUM_IDS - 1) : max_x;
   assign top_id     = top_x[IdW-1:0];
   assign id_x       = XW'(id_ff);
   assign rid_x      = XW'(req_id);
   assign cand_x     = XW'(cand_ff);
   assign id_ok      = (id_ff != '0) && (id_x <= top_x);
   assign age        = ts_ff - stamp_rd_ff;
   assign stamp_init = afid_pkg::TS_W'(0) - afid_pkg::TS_W'(min_free_ff);
   assign grant      = (count_ff != '0) && (age >= afid_pkg::TS_W'(min_free_ff));
   assign free_ok    = id_ok && bit_rd_ff && (count_ff < CntW'(NUM_IDS));
   assign commit     = cmd.alloc_commit || cmd.free_commit || cmd.query_commit ||
                       cmd.nop_commit;

   always_comb begin
      rsp_id_in   = '0;
      rsp_flag_in = 1'b0;
      if (cmd.alloc_commit && grant) begin
         rsp_id_in   = cand_x[afid_pkg::ID_W-1:0];
         rsp_flag_in = 1'b1;
      end else if (cmd.free_commit) begin
         rsp_flag_in = free_ok;
      end else if (cmd.query_commit) begin
         rsp_flag_in = id_ok && bit_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_id_ff    <= afid_pkg::MAX_ID_RESET;
         min_free_ff  <= afid_pkg::MIN_FREE_RESET;
         sweep_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (reinit) begin
            unique case (csr_index)
               afid_pkg::REG_MAX_ID:   max_id_ff   <= csr_data[afid_pkg::ID_W-1:0];
               afid_pkg::REG_MIN_FREE: min_free_ff <= csr_data[afid_pkg::TIME_W-1:0];
               default: ;
            endcase
            sweep_ff <= '0;
         end else if (cmd.sweep) begin
            sweep_ff <= next_slot(sweep_ff);
            if (sweep_ff == LastIdx) begin
               head_ff  <= '0;
               tail_ff  <= top_id;
               count_ff <= CntW'(top_id);
            end
         end
         if (cmd.alloc_commit && grant) begin
            head_ff  <= next_slot(head_ff);
            count_ff <= count_ff - 1'b1;
         end
         if (cmd.free_commit && free_ok) begin
            tail_ff  <= next_slot(tail_ff);
            count_ff <= count_ff + 1'b1;
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         id_ff <= req_id;
         ts_ff <= req_timestamp;
      end
      if (commit) begin
         rsp_id_ff   <= rsp_id_in;
         rsp_flag_ff <= rsp_flag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sweep) begin
         queue_mem[sweep_ff] <= IdW'(sweep_ff + 1'b1);
      end else if (cmd.free_commit && free_ok) begin
         queue_mem[tail_ff] <= id_x[IdW-1:0];
      end
      if (cmd.rd_head) cand_ff <= queue_mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.sweep) begin
         stamp_mem[sweep_ff] <= stamp_init;
      end else if (cmd.free_commit && free_ok) begin
         stamp_mem[id_x[IdW-1:0]] <= ts_ff;
      end
      if (cmd.rd_stamp) stamp_rd_ff <= stamp_mem[cand_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.sweep) begin
         alloc_mem[sweep_ff] <= 1'b0;
      end else if (cmd.alloc_commit && grant) begin
         alloc_mem[cand_ff] <= 1'b1;
      end else if (cmd.free_commit && free_ok) begin
         alloc_mem[id_x[IdW-1:0]] <= 1'b0;
      end
      if (cmd.rd_bit) bit_rd_ff <= alloc_mem[rid_x[IdW-1:0]];
   end

   assign status.reinit     = reinit;
   assign status.sweep_last = (sweep_ff == LastIdx);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_granted_id = rsp_id_ff;
   assign rsp_flag       = rsp_flag_ff;

endmodule

[src/aged_fifo_id_allocator.sv]
// ----------------------------------------------------------------------------
// aged_fifo_id_allocator
// Free-list ID allocator with a quarantine time on reused IDs.
// ----------------------------------------------------------------------------
// Channels: req_if carries kind (allocate, free, query), id_in and timestamp;
// rsp_if returns one word per request with granted_id and flag; csr_if
// writes max_id (index 0) and min_free_time (index 1) and is always ready.
// Allocate grants the oldest free ID once it has been free long enough.
// Free returns an allocated ID to the tail; query reports allocation.
// Steps from accept to response valid: allocate reads the queue head,
// then the stamp at that ID, then compares the age at commit; free and
// query read the allocated bit, then commit; an unused kind commits with
// no read. One request is in work at a time: the next is not accepted
// until the current one has committed.
// Reset and every write to a defined register start a clearing pass over
// all NUM_IDS slots that refills the queue, stamps and allocated bits;
// req_if is not ready during it.
// The response is registered: the next request is accepted while a
// response waits, and its commit holds until the response slot is free.
// ----------------------------------------------------------------------------
`include "aged_fifo_id_allocator_assert.svh"

module aged_fifo_id_allocator #(
   parameter int NUM_IDS = afid_pkg::NUM_IDS_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   afid_req_if.sink  req_if,
   afid_rsp_if.source rsp_if,
   afid_csr_if.sink  csr_if
);

   afid_pkg::cmd_type    cmd;
   afid_pkg::status_type status;

   assign csr_if.ready = 1'b1;

   afid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_kind  (req_if.kind),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   afid_datapath #(
      .NUM_IDS (NUM_IDS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_valid      (csr_if.valid),
      .csr_index      (csr_if.index),
      .csr_data       (csr_if.data),
      .req_id         (req_if.id_in),
      .req_timestamp  (req_if.timestamp),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .rsp_granted_id (rsp_if.granted_id),
      .rsp_flag       (rsp_if.flag)
   );

   `AFID_ASSERT_NEXT(a_reinit_blocks_req, clock, reset, status.reinit, !req_if.ready, "request accepted right after reinit")
   `AFID_ASSERT_NEXT(a_one_in_work, clock, reset, req_if.valid && req_if.ready, !req_if.ready, "second request accepted while one is in work")
   `AFID_ASSERT_SAME(a_grant_has_flag, clock, reset, rsp_if.valid && rsp_if.granted_id != '0, rsp_if.flag, "granted ID without flag")

endmodule
